FILE: rtl/si_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// si_pkg: shared types and constants for the segment intersection block
// Transaction structs, datapath widths and pipeline depths.
// ----------------------------------------------------------------------------
package si_pkg;

    localparam int COORD_W = 32;                 // Q16.16 coordinate
    localparam int DIFF_W  = COORD_W + 1;        // coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;         // product of two differences
    localparam int MAG_W   = PROD_W;             // magnitude of a cross product
    localparam int NUM_W   = MAG_W + DIFF_W;     // scaled numerator
    localparam int QB      = 36;                 // quotient bits resolved by the divider
    localparam int QR_W    = QB + 1;             // quotient after rounding
    localparam int PT_W    = COORD_W + 4;        // unclipped point
    localparam int DIV_LAT = 3 + QB + 2;         // divider lane latency
    localparam int Q_DEPTH = 2;                  // front-to-back queue depth
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
    } t_item;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
    } t_result;

    // classified job handed from the front to the back
    typedef struct packed {
        logic [MAG_W-1:0]          num_mag;
        logic [MAG_W-1:0]          den_mag;
        logic                      den_nz;
        logic [DIFF_W-1:0]         dir_x;
        logic [DIFF_W-1:0]         dir_y;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] y_hi;
    } t_job;

    // bounding box overlap carried beside the divider lanes
    typedef struct packed {
        logic                      den_nz;
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] y_hi;
    } t_box;

endpackage
`default_nettype wire

FILE: rtl/segment_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection: 2D line segment intersection, signed Q16.16
// Front computes cross products, back divides and tests the bounding boxes.
// ----------------------------------------------------------------------------
// A transaction is taken on any cycle with start high and busy low, one per
// cycle, and its result appears on o_result with o_done high for one cycle,
// in order, after 3 front stages, one queue slot, 41 stages of the
// divider lanes (one quotient bit per stage over 36 bits) and the output
// register. The receiver cannot stall the block; the back drains the queue
// every cycle, so busy stays low in operation. When no intersection is found
// the coordinates read zero.
module segment_intersection (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire si_pkg::t_item    i_item,
    output logic                  busy,
    output logic                  o_done,
    output si_pkg::t_result       o_result
);
    import si_pkg::*;

    logic f_valid, q_valid, q_full;
    t_job f_job, q_job;

    assign busy = q_full;

    si_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_job   (f_job)
    );

    si_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .i_ready (1'b1),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    si_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // the back pops every cycle, so the queue must never fill
    a_never_full: assert property (@(posedge i_clk) disable iff (!i_rst_n) !q_full)
        else $error("job queue filled up");

    // a miss reports zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found) |-> (o_result.cross_x == '0 && o_result.cross_y == '0))
        else $error("nonzero point without intersection");

    // every front job enters the queue and leaves it the next cycle
    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |=> q_valid)
        else $error("front job not presented to back");

endmodule
`default_nettype wire

FILE: rtl/si_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// si_front: segment differences, cross products and classification
// Three-stage pipeline producing one job per accepted transaction.
// ----------------------------------------------------------------------------
module si_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire si_pkg::t_item i_item,
    output logic               o_valid,
    output si_pkg::t_job       o_job
);
    import si_pkg::*;

    function automatic logic signed [DIFF_W-1:0] f_sub(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        f_sub = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    function automatic logic [DIFF_W-1:0] f_abs(input logic signed [DIFF_W-1:0] a);
        f_abs = a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
    endfunction

    logic                      r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0]  r_d1x, r_d1y, r_d2x, r_d2y, r_wx, r_wy;
    logic signed [COORD_W-1:0] r1_bx, r1_by, r1_xlo, r1_xhi, r1_ylo, r1_yhi;
    logic signed [PROD_W-1:0]  r_pw1, r_pw2, r_pd1, r_pd2;
    logic [DIFF_W-1:0]         r2_ax, r2_ay;
    logic                      r2_sx, r2_sy;
    logic signed [COORD_W-1:0] r2_bx, r2_by, r2_xlo, r2_xhi, r2_ylo, r2_yhi;
    t_job                      r_job;

    logic signed [COORD_W-1:0] n_min1x, n_max1x, n_min1y, n_max1y;
    logic signed [COORD_W-1:0] n_min2x, n_max2x, n_min2y, n_max2y;
    logic signed [MAG_W:0]     n_num, n_den;

    always_comb begin
        n_min1x = (i_item.first_start_x < i_item.first_end_x) ? i_item.first_start_x
                                                               : i_item.first_end_x;
        n_max1x = (i_item.first_start_x < i_item.first_end_x) ? i_item.first_end_x
                                                               : i_item.first_start_x;
        n_min1y = (i_item.first_start_y < i_item.first_end_y) ? i_item.first_start_y
                                                               : i_item.first_end_y;
        n_max1y = (i_item.first_start_y < i_item.first_end_y) ? i_item.first_end_y
                                                               : i_item.first_start_y;
        n_min2x = (i_item.second_start_x < i_item.second_end_x) ? i_item.second_start_x
                                                                 : i_item.second_end_x;
        n_max2x = (i_item.second_start_x < i_item.second_end_x) ? i_item.second_end_x
                                                                 : i_item.second_start_x;
        n_min2y = (i_item.second_start_y < i_item.second_end_y) ? i_item.second_start_y
                                                                 : i_item.second_end_y;
        n_max2y = (i_item.second_start_y < i_item.second_end_y) ? i_item.second_end_y
                                                                 : i_item.second_start_y;
        n_num = $signed({r_pw1[PROD_W-1], r_pw1}) - $signed({r_pw2[PROD_W-1], r_pw2});
        n_den = $signed({r_pd1[PROD_W-1], r_pd1}) - $signed({r_pd2[PROD_W-1], r_pd2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: differences and box overlap
        r_d1x  <= f_sub(i_item.first_end_x, i_item.first_start_x);
        r_d1y  <= f_sub(i_item.first_end_y, i_item.first_start_y);
        r_d2x  <= f_sub(i_item.second_end_x, i_item.second_start_x);
        r_d2y  <= f_sub(i_item.second_end_y, i_item.second_start_y);
        r_wx   <= f_sub(i_item.first_end_x, i_item.second_end_x);
        r_wy   <= f_sub(i_item.first_end_y, i_item.second_end_y);
        r1_bx  <= i_item.second_end_x;
        r1_by  <= i_item.second_end_y;
        r1_xlo <= (n_min1x > n_min2x) ? n_min1x : n_min2x;
        r1_xhi <= (n_max1x < n_max2x) ? n_max1x : n_max2x;
        r1_ylo <= (n_min1y > n_min2y) ? n_min1y : n_min2y;
        r1_yhi <= (n_max1y < n_max2y) ? n_max1y : n_max2y;
        // stage 2: products, direction magnitudes and signs
        r_pw1  <= r_wx * r_d1y;
        r_pw2  <= r_wy * r_d1x;
        r_pd1  <= r_d2x * r_d1y;
        r_pd2  <= r_d2y * r_d1x;
        r2_ax  <= f_abs(r_d2x);
        r2_ay  <= f_abs(r_d2y);
        r2_sx  <= r_d2x[DIFF_W-1];
        r2_sy  <= r_d2y[DIFF_W-1];
        r2_bx  <= r1_bx;
        r2_by  <= r1_by;
        r2_xlo <= r1_xlo;
        r2_xhi <= r1_xhi;
        r2_ylo <= r1_ylo;
        r2_yhi <= r1_yhi;
        // stage 3: cross products, signs and magnitudes
        r_job.num_mag <= n_num[MAG_W] ? MAG_W'(-n_num) : MAG_W'(n_num);
        r_job.den_mag <= n_den[MAG_W] ? MAG_W'(-n_den) : MAG_W'(n_den);
        r_job.den_nz  <= (n_den != '0);
        r_job.dir_x   <= r2_ax;
        r_job.dir_y   <= r2_ay;
        r_job.neg_x   <= n_num[MAG_W] ^ n_den[MAG_W] ^ r2_sx;
        r_job.neg_y   <= n_num[MAG_W] ^ n_den[MAG_W] ^ r2_sy;
        r_job.base_x  <= r2_bx;
        r_job.base_y  <= r2_by;
        r_job.x_lo    <= r2_xlo;
        r_job.x_hi    <= r2_xhi;
        r_job.y_lo    <= r2_ylo;
        r_job.y_hi    <= r2_yhi;
    end

    assign o_valid = r_v3;
    assign o_job   = r_job;

endmodule
`default_nettype wire

FILE: rtl/si_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// si_queue: small job queue between front and back
// Pops whenever an entry is present and i_ready is high; full marks back pressure to the front.
// ----------------------------------------------------------------------------
module si_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire si_pkg::t_job i_job,
    input  wire logic         i_ready,
    output logic              o_valid,
    output si_pkg::t_job      o_job,
    output logic              o_full
);
    import si_pkg::*;

    t_job             r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_CW-1:0]  r_cnt;
    logic             n_pop, n_push;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_job   = r_mem[r_rd];
    assign n_pop   = o_valid && i_ready;
    assign n_push  = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (n_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CW'(n_push) - Q_CW'(n_pop);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/si_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// si_div: one axis of the intersection offset
// Scales the numerator by the direction, divides by the denominator one
// quotient bit per stage, rounds half away from zero, checks the range and adds the base.
// ----------------------------------------------------------------------------
module si_div (
    input  wire logic                              i_clk,
    input  wire logic [si_pkg::MAG_W-1:0]          i_num,
    input  wire logic [si_pkg::MAG_W-1:0]          i_den,
    input  wire logic [si_pkg::DIFF_W-1:0]         i_dir,
    input  wire logic                              i_neg,
    input  wire logic signed [si_pkg::COORD_W-1:0] i_base,
    output logic                                   o_ok,
    output logic signed [si_pkg::PT_W-1:0]         o_point
);
    import si_pkg::*;

    localparam int LO_W = MAG_W - DIFF_W;
    localparam int HI_W = NUM_W - QB;
    localparam logic [QR_W-1:0] Q_LIMIT = QR_W'(64'd1 << 34);

    // stage 1 / 2: partial products, then the full numerator
    logic [2*DIFF_W-1:0]       r_pl, r_ph;
    logic [NUM_W-1:0]          r_n;
    logic [MAG_W-1:0]          r_d1, r_d2;
    logic                      r_g1, r_g2;
    logic signed [COORD_W-1:0] r_b1, r_b2;

    // divider stages: index 0 is the initial remainder
    logic [MAG_W-1:0]          r_rem [0:QB];
    logic [QB-1:0]             r_nlo [0:QB];
    logic [QB-1:0]             r_q   [0:QB];
    logic [MAG_W-1:0]          r_den [0:QB];
    logic                      r_ovf [0:QB];
    logic                      r_neg [0:QB];
    logic signed [COORD_W-1:0] r_base [0:QB];

    logic [QR_W-1:0]           r_qr;
    logic                      r_okq, r_ng;
    logic signed [COORD_W-1:0] r_bq;
    logic                      r_ok;
    logic signed [PT_W-1:0]    r_pt;

    logic [MAG_W:0]            n_t   [0:QB-1];
    logic                      n_ge  [0:QB-1];
    logic [MAG_W-1:0]          n_rem [0:QB-1];
    logic                      n_rnd;
    logic signed [PT_W-1:0]    n_base;

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_t[k]   = {r_rem[k], r_nlo[k][QB-1]};
            n_ge[k]  = (n_t[k] >= {1'b0, r_den[k]});
            n_rem[k] = n_ge[k] ? MAG_W'(n_t[k] - {1'b0, r_den[k]}) : MAG_W'(n_t[k]);
        end
        n_rnd  = ({r_rem[QB], 1'b0} >= {1'b0, r_den[QB]});
        n_base = PT_W'(r_bq);
    end

    always_ff @(posedge i_clk) begin
        r_pl <= i_num[DIFF_W-1:0] * i_dir;
        r_ph <= {{(2*DIFF_W-LO_W){1'b0}}, i_num[MAG_W-1:DIFF_W]} * i_dir;
        r_d1 <= i_den;
        r_g1 <= i_neg;
        r_b1 <= i_base;

        r_n  <= NUM_W'(r_pl) + (NUM_W'(r_ph) << DIFF_W);
        r_d2 <= r_d1;
        r_g2 <= r_g1;
        r_b2 <= r_b1;

        // quotients of 2^QB or more can never land in the box: flag overflow
        r_rem[0]  <= MAG_W'(r_n[NUM_W-1:QB]);
        r_ovf[0]  <= (MAG_W'(r_n[NUM_W-1:QB]) >= r_d2) || (HI_W > MAG_W);
        r_nlo[0]  <= r_n[QB-1:0];
        r_q[0]    <= '0;
        r_den[0]  <= r_d2;
        r_neg[0]  <= r_g2;
        r_base[0] <= r_b2;

        for (int k = 0; k < QB; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_nlo[k+1]  <= r_nlo[k] << 1;
            r_q[k+1]    <= {r_q[k][QB-2:0], n_ge[k]};
            r_den[k+1]  <= r_den[k];
            r_ovf[k+1]  <= r_ovf[k];
            r_neg[k+1]  <= r_neg[k];
            r_base[k+1] <= r_base[k];
        end

        // round half away from zero, then range check
        r_qr  <= {1'b0, r_q[QB]} + QR_W'(n_rnd);
        r_okq <= !r_ovf[QB];
        r_ng  <= r_neg[QB];
        r_bq  <= r_base[QB];

        r_ok  <= r_okq && (r_qr <= Q_LIMIT);
        r_pt  <= r_ng ? n_base - $signed(PT_W'(r_qr)) : n_base + $signed(PT_W'(r_qr));
    end

    assign o_ok    = r_ok;
    assign o_point = r_pt;

endmodule
`default_nettype wire

FILE: rtl/si_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// si_back: division lanes and bounding box test
// Two axis lanes run side by side; the box bounds ride a matching delay line.
// ----------------------------------------------------------------------------
module si_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire si_pkg::t_job i_job,
    output logic              o_done,
    output si_pkg::t_result   o_result
);
    import si_pkg::*;

    logic                   r_vld [0:DIV_LAT-1];
    t_box                   r_box [0:DIV_LAT-1];
    logic                   w_okx, w_oky;
    logic signed [PT_W-1:0] w_px, w_py;
    logic                   n_found;
    t_box                   n_in_box;
    t_box                   w_box;
    logic                   r_done;
    t_result                r_res;

    assign n_in_box.den_nz = i_job.den_nz;
    assign n_in_box.x_lo   = i_job.x_lo;
    assign n_in_box.x_hi   = i_job.x_hi;
    assign n_in_box.y_lo   = i_job.y_lo;
    assign n_in_box.y_hi   = i_job.y_hi;

    si_div u_div_x (
        .i_clk   (i_clk),
        .i_num   (i_job.num_mag),
        .i_den   (i_job.den_mag),
        .i_dir   (i_job.dir_x),
        .i_neg   (i_job.neg_x),
        .i_base  (i_job.base_x),
        .o_ok    (w_okx),
        .o_point (w_px)
    );

    si_div u_div_y (
        .i_clk   (i_clk),
        .i_num   (i_job.num_mag),
        .i_den   (i_job.den_mag),
        .i_dir   (i_job.dir_y),
        .i_neg   (i_job.neg_y),
        .i_base  (i_job.base_y),
        .o_ok    (w_oky),
        .o_point (w_py)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_done <= r_vld[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_box[0] <= n_in_box;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_box[k] <= r_box[k-1];
        end
    end

    assign w_box = r_box[DIV_LAT-1];

    always_comb begin
        n_found = w_box.den_nz && w_okx && w_oky
               && (w_px >= PT_W'(w_box.x_lo)) && (w_px <= PT_W'(w_box.x_hi))
               && (w_py >= PT_W'(w_box.y_lo)) && (w_py <= PT_W'(w_box.y_hi));
    end

    always_ff @(posedge i_clk) begin
        r_res.found   <= n_found;
        r_res.cross_x <= n_found ? w_px[COORD_W-1:0] : '0;
        r_res.cross_y <= n_found ? w_py[COORD_W-1:0] : '0;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

FILE: tb/sv/tb_segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection: self-checking bench for the segment intersection
// Drives segment pairs through the command handshake, predicts each point
// with exact wide integer arithmetic unless its row gives the result, and compares results in order.
// ----------------------------------------------------------------------------
module tb_segment_intersection;
    import si_pkg::*;

    localparam int LATENCY     = 46;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 1800;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   i_item = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    segment_intersection u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_result points_due[$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_found = 0;
    int      n_sent = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;

    task automatic report_mismatch(input string what, input t_result got, input t_result want);
        n_errors++;
        $display("mismatch %0s: got found=%0d x=%0d y=%0d, want found=%0d x=%0d y=%0d",
                 what, got.found, got.cross_x, got.cross_y,
                 want.found, want.cross_x, want.cross_y);
    endtask

    // divide rounded, ties away from zero; magnitudes only
    function automatic logic [255:0] div_round(input logic [255:0] n, input logic [255:0] d);
        logic [255:0] q;
        logic [255:0] r;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 1;
        return q;
    endfunction

    function automatic t_result intersect_point(input t_item it);
        logic signed [255:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
        logic signed [255:0] d1x, d1y, d2x, d2y, wx, wy, num, den, px, py;
        logic signed [255:0] mag_n, mag_d, qx, qy;
        t_result res;
        res = '0;
        s1x = it.first_start_x;  s1y = it.first_start_y;
        e1x = it.first_end_x;    e1y = it.first_end_y;
        s2x = it.second_start_x; s2y = it.second_start_y;
        e2x = it.second_end_x;   e2y = it.second_end_y;
        d1x = e1x - s1x; d1y = e1y - s1y;
        d2x = e2x - s2x; d2y = e2y - s2y;
        wx = e1x - e2x;  wy = e1y - e2y;
        num = wx * d1y - wy * d1x;
        den = d2x * d1y - d2y * d1x;
        if (den == 0) return res;
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        qx = div_round(mag_n * ((d2x < 0) ? -d2x : d2x), mag_d);
        qy = div_round(mag_n * ((d2y < 0) ? -d2y : d2y), mag_d);
        if (qx > (256'sd1 <<< 34) || qy > (256'sd1 <<< 34)) return res;
        px = e2x + ((((num < 0) != (den < 0)) != (d2x < 0)) ? -qx : qx);
        py = e2y + ((((num < 0) != (den < 0)) != (d2y < 0)) ? -qy : qy);
        if (px < ((s1x < e1x) ? s1x : e1x) || px > ((s1x < e1x) ? e1x : s1x)) return res;
        if (py < ((s1y < e1y) ? s1y : e1y) || py > ((s1y < e1y) ? e1y : s1y)) return res;
        if (px < ((s2x < e2x) ? s2x : e2x) || px > ((s2x < e2x) ? e2x : s2x)) return res;
        if (py < ((s2y < e2y) ? s2y : e2y) || py > ((s2y < e2y) ? e2y : s2y)) return res;
        res.found   = 1'b1;
        res.cross_x = px[31:0];
        res.cross_y = py[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (points_due.size() == 0) begin
                report_mismatch("unexpected result", o_result, '0);
            end else begin
                t_result want;
                want = points_due.pop_front();
                if (o_result.found !== want.found) report_mismatch("found", o_result, want);
                else if (o_result.cross_x !== want.cross_x)
                    report_mismatch("cross_x", o_result, want);
                else if (o_result.cross_y !== want.cross_y)
                    report_mismatch("cross_y", o_result, want);
                n_checked++;
                if (want.found) n_found++;
            end
        end
    end

    // hold start until a transaction is taken; random gaps ahead of it
    task automatic send_pair(input t_item it, input logic use_given, input t_result given);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        points_due.push_back(use_given ? given : intersect_point(it));
        n_sent++;
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return {16'($urandom_range(15, 0) - 8), 16'($urandom_range(65535, 0))};
            default: return 32'($urandom_range(1 << 20, 0)) - 32'(1 << 19);
        endcase
    endfunction

    typedef struct {
        t_item   it;
        logic    known;
        t_result want;
    } t_row;

    t_row rows[$];
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXC = 32'h7fff_ffff;
    localparam logic [31:0] MINC = 32'h8000_0000;

    initial begin
        t_item it;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // simple cross at (1,1): X shape
        rows.push_back('{'{0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0}, 1, '{1, ONE, ONE}});
        // parallel and collinear: no point
        rows.push_back('{'{0, 0, ONE, 0, 0, ONE, ONE, ONE}, 1, '0});
        rows.push_back('{'{0, 0, 2*ONE, 0, ONE, 0, 3*ONE, 0}, 1, '0});
        // zero length segments
        rows.push_back('{'{ONE, ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE}, 1, '0});
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, '0});
        // vertical first segment
        rows.push_back('{'{ONE, 0, ONE, 4*ONE, 0, ONE, 4*ONE, ONE}, 1, '{1, ONE, ONE}});
        // lines meet outside the boxes
        rows.push_back('{'{0, 0, ONE, 0, 3*ONE, ONE, 3*ONE, 2*ONE}, 1, '0});
        // touching at an endpoint
        rows.push_back('{'{0, 0, ONE, ONE, ONE, ONE, 2*ONE, 0}, 1, '{1, ONE, ONE}});
        // full range extremes
        rows.push_back('{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 0, '0});
        rows.push_back('{'{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC}, 0, '0});
        rows.push_back('{'{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC}, 1, '{1, 0, 0}});
        rows.push_back('{'{32'hffff_ffff, MAXC, 1, MINC, MAXC, 32'hffff_ffff, MINC, 1}, 0, '0});
        // rounding ties and far-away crossing of nearly parallel lines
        rows.push_back('{'{0, 0, 3, 1, 0, 1, 3, 0}, 0, '0});
        rows.push_back('{'{0, 0, 1, 1, 1, 0, 0, 1}, 0, '0});
        rows.push_back('{'{MINC, MINC, MAXC, MAXC, MINC, MINC + 1, MAXC, MAXC}, 0, '0});
        rows.push_back('{'{0, 0, MAXC, 1, 0, 1, MAXC, 3}, 0, '0});

        foreach (rows[k]) send_pair(rows[k].it, rows[k].known, rows[k].want);

        // hold off until the pipe drains
        start <= 1'b0;
        while (points_due.size() != 0) @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 88 : 0;
            for (int n = 0; n < ((phase == 1) ? N_RANDOM / 6 : N_RANDOM * 5 / 12); n++) begin
                int mode;
                mode = $urandom_range(2, 0);
                it.first_start_x  = rand_coord(mode);
                it.first_start_y  = rand_coord(mode);
                it.first_end_x    = rand_coord(mode);
                it.first_end_y    = rand_coord(mode);
                it.second_start_x = rand_coord(mode);
                it.second_start_y = rand_coord(mode);
                it.second_end_x   = rand_coord(mode);
                it.second_end_y   = rand_coord(mode);
                // mostly build a second segment that crosses the first one
                if ($urandom_range(3, 0) != 0) begin
                    logic signed [31:0] mx, my;
                    mx = (it.first_start_x >>> 1) + (it.first_end_x >>> 1);
                    my = (it.first_start_y >>> 1) + (it.first_end_y >>> 1);
                    it.second_end_x = mx + (mx - it.second_start_x);
                    it.second_end_y = my + (my - it.second_start_y);
                    if ($urandom_range(7, 0) == 0) it.second_end_x = it.second_start_x;
                end
                send_pair(it, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (points_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("segment pairs sent %0d, results checked %0d, intersections found %0d",
                 n_sent, n_checked, n_found);
        $display("covered parallel, degenerate, vertical, endpoint and full-range cases");
        if (n_errors == 0 && points_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
